[hw/rtl/mhpq_pkg.sv]
package mhpq_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 7;
   localparam int STAT_W = 2;

   localparam logic              CMD_INSERT = 1'b0;
   localparam logic              CMD_DELETE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

   // register word index (byte address bit 2)
   localparam logic              REG_CAPACITY = 1'b0;
   localparam logic [CNT_W-1:0]  CAP_RESET    = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DEL_LD,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_L,
      ST_DN_R,
      ST_DN_CMP,
      ST_DN_DEC
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } cmp_req_type;

   typedef struct packed {
      logic gt;   // signed a > b
      logic eq;
   } cmp_res_type;

endpackage

[hw/rtl/mhpq_mem.sv]
module mhpq_mem #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [$clog2(DEPTH)-1:0]          waddr,
   input  logic [mhpq_pkg::DATA_W-1:0]       wdata,
   input  logic [$clog2(DEPTH)-1:0]          raddr,
   output logic [mhpq_pkg::DATA_W-1:0]       rdata
);

   logic [mhpq_pkg::DATA_W-1:0] heap_mem_ff [DEPTH];
   logic [mhpq_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem_ff[waddr] <= wdata;
      end
      rdata_ff <= heap_mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/mhpq_cmp.sv]
module mhpq_cmp (
   input  mhpq_pkg::cmp_req_type req,
   output mhpq_pkg::cmp_res_type res
);

   always_comb begin
      res.gt = $signed(req.a) > $signed(req.b);
      res.eq = req.a == req.b;
   end

endmodule

[hw/rtl/mhpq_ctrl.sv]
module mhpq_ctrl #(
   parameter int DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               cmd,
   input  logic [mhpq_pkg::DATA_W-1:0]        value,
   input  logic [mhpq_pkg::CNT_W-1:0]         capacity,
   output logic                               busy,
   output logic                               mem_we,
   output logic [$clog2(DEPTH)-1:0]           mem_waddr,
   output logic [mhpq_pkg::DATA_W-1:0]        mem_wdata,
   output logic [$clog2(DEPTH)-1:0]           mem_raddr,
   input  logic [mhpq_pkg::DATA_W-1:0]        mem_rdata,
   output mhpq_pkg::cmp_req_type              cmp_req,
   input  mhpq_pkg::cmp_res_type              cmp_res,
   output logic                               rsp_valid,
   output logic [mhpq_pkg::STAT_W-1:0]        rsp_status,
   output logic [mhpq_pkg::CNT_W-1:0]         rsp_count,
   output logic [mhpq_pkg::DATA_W-1:0]        rsp_max_value,
   output logic                               rsp_empty_res
);

   localparam int AW = $clog2(DEPTH);
   localparam int XW = ((AW > mhpq_pkg::CNT_W) ? AW : mhpq_pkg::CNT_W) + 2;

   mhpq_pkg::state_type state_ff, state_in;

   logic [mhpq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [mhpq_pkg::CNT_W-1:0]  scan_ff, scan_in;
   logic [AW-1:0]               pos_ff, pos_in;
   logic [AW-1:0]               chk_idx_ff, chk_idx_in;
   logic [AW-1:0]               best_ff, best_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic                        ins_ff, ins_in;
   logic [mhpq_pkg::DATA_W-1:0] val_ff, val_in;
   logic [mhpq_pkg::DATA_W-1:0] key_ff, key_in;
   logic [mhpq_pkg::DATA_W-1:0] bestv_ff, bestv_in;
   logic [mhpq_pkg::DATA_W-1:0] root_ff, root_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mhpq_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [mhpq_pkg::CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [mhpq_pkg::DATA_W-1:0] rsp_max_ff, rsp_max_in;
   logic                        rsp_empty_ff, rsp_empty_in;

   logic [XW-1:0] count_x, pos_x, scan_x, limit_x, cap_x, lchild_x, rchild_x;
   logic [XW-1:0] last_x;
   logic [AW-1:0] parent;
   logic          fin;
   logic [mhpq_pkg::STAT_W-1:0] fin_status;

   always_comb begin
      count_x  = XW'(count_ff);
      pos_x    = XW'(pos_ff);
      scan_x   = XW'(scan_ff);
      cap_x    = XW'(capacity);
      limit_x  = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);
      lchild_x = (pos_x << 1) + XW'(1);
      rchild_x = lchild_x + XW'(1);
      last_x   = count_x - XW'(1);
      parent   = (pos_ff - AW'(1)) >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      chk_idx_ff    <= chk_idx_in;
      chk_vld_ff    <= chk_vld_in;
      best_ff       <= best_in;
      ins_ff        <= ins_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      bestv_ff      <= bestv_in;
      root_ff       <= root_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      pos_in     = pos_ff;
      chk_idx_in = chk_idx_ff;
      chk_vld_in = chk_vld_ff;
      best_in    = best_ff;
      ins_in     = ins_ff;
      val_in     = val_ff;
      key_in     = key_ff;
      bestv_in   = bestv_ff;

      mem_we     = 1'b0;
      mem_waddr  = pos_ff;
      mem_wdata  = val_ff;
      mem_raddr  = scan_x[AW-1:0];
      cmp_req.a  = mem_rdata;
      cmp_req.b  = key_ff;
      fin        = 1'b0;
      fin_status = mhpq_pkg::STATUS_DONE;

      case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            if (start) begin
               if (cmd == mhpq_pkg::CMD_INSERT) begin
                  if (count_x >= limit_x) begin
                     fin        = 1'b1;
                     fin_status = mhpq_pkg::STATUS_FULL;
                  end else begin
                     val_in   = value;
                     pos_in   = count_x[AW-1:0];
                     count_in = count_ff + mhpq_pkg::CNT_W'(1);
                     ins_in   = 1'b1;
                     state_in = mhpq_pkg::ST_UP_RD;
                  end
               end else begin
                  key_in     = value;
                  scan_in    = '0;
                  chk_vld_in = 1'b0;
                  ins_in     = 1'b0;
                  state_in   = mhpq_pkg::ST_SCAN;
               end
            end
         end
         // one read issued and one entry checked per cycle
         mhpq_pkg::ST_SCAN: begin
            if (chk_vld_ff && cmp_res.eq) begin
               count_in = count_ff - mhpq_pkg::CNT_W'(1);
               if (XW'(chk_idx_ff) == last_x) begin
                  fin      = 1'b1;
                  state_in = mhpq_pkg::ST_IDLE;
               end else begin
                  mem_raddr = last_x[AW-1:0];
                  pos_in    = chk_idx_ff;
                  state_in  = mhpq_pkg::ST_DEL_LD;
               end
            end else if (scan_x >= count_x) begin
               fin        = 1'b1;
               fin_status = mhpq_pkg::STATUS_NOT_FOUND;
               state_in   = mhpq_pkg::ST_IDLE;
            end else begin
               chk_vld_in = 1'b1;
               chk_idx_in = scan_x[AW-1:0];
               scan_in    = scan_ff + mhpq_pkg::CNT_W'(1);
            end
         end
         mhpq_pkg::ST_DEL_LD: begin
            val_in   = mem_rdata;
            state_in = mhpq_pkg::ST_UP_RD;
         end
         mhpq_pkg::ST_UP_RD: begin
            if (pos_ff == '0) begin
               if (ins_ff) begin
                  mem_we   = 1'b1;
                  fin      = 1'b1;
                  state_in = mhpq_pkg::ST_IDLE;
               end else begin
                  state_in = mhpq_pkg::ST_DN_L;
               end
            end else begin
               mem_raddr = parent;
               state_in  = mhpq_pkg::ST_UP_CMP;
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            cmp_req.a = val_ff;
            cmp_req.b = mem_rdata;
            if (cmp_res.gt) begin
               // parent moves down into the hole
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               pos_in    = parent;
               state_in  = mhpq_pkg::ST_UP_RD;
            end else if (ins_ff) begin
               mem_we   = 1'b1;
               fin      = 1'b1;
               state_in = mhpq_pkg::ST_IDLE;
            end else begin
               state_in = mhpq_pkg::ST_DN_L;
            end
         end
         mhpq_pkg::ST_DN_L: begin
            if (lchild_x >= count_x) begin
               mem_we   = 1'b1;
               fin      = 1'b1;
               state_in = mhpq_pkg::ST_IDLE;
            end else begin
               mem_raddr = lchild_x[AW-1:0];
               state_in  = mhpq_pkg::ST_DN_R;
            end
         end
         mhpq_pkg::ST_DN_R: begin
            best_in  = lchild_x[AW-1:0];
            bestv_in = mem_rdata;
            if (rchild_x < count_x) begin
               mem_raddr = rchild_x[AW-1:0];
               state_in  = mhpq_pkg::ST_DN_CMP;
            end else begin
               state_in = mhpq_pkg::ST_DN_DEC;
            end
         end
         mhpq_pkg::ST_DN_CMP: begin
            cmp_req.a = mem_rdata;
            cmp_req.b = bestv_ff;
            if (cmp_res.gt) begin
               best_in  = rchild_x[AW-1:0];
               bestv_in = mem_rdata;
            end
            state_in = mhpq_pkg::ST_DN_DEC;
         end
         mhpq_pkg::ST_DN_DEC: begin
            cmp_req.a = bestv_ff;
            cmp_req.b = val_ff;
            mem_we    = 1'b1;
            if (cmp_res.gt) begin
               // larger child moves up into the hole
               mem_wdata = bestv_ff;
               pos_in    = best_ff;
               state_in  = mhpq_pkg::ST_DN_L;
            end else begin
               fin      = 1'b1;
               state_in = mhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase

      // shadow copy of the root slot
      root_in = (mem_we && mem_waddr == '0) ? mem_wdata : root_ff;

      rsp_valid_in  = fin;
      rsp_status_in = fin_status;
      rsp_count_in  = count_in;
      rsp_empty_in  = count_in == '0;
      rsp_max_in    = (count_in == '0) ? '0 : root_in;
   end

   assign busy          = state_ff != mhpq_pkg::ST_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_max_value = rsp_max_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule

[hw/rtl/max_heap_priority_queue_top.sv]
// Binary max-heap of signed 32-bit values. A transaction is taken at a rising
// edge with start high and busy low; req_cmd selects insert or delete of one
// occurrence of req_value. Every transaction gives exactly one result, shown
// for a single cycle with rsp_valid: status (done, full, not found), the new
// count, the current maximum (0 when empty) and an empty flag. The receiver
// cannot stall, so rsp_valid must be sampled whenever it is high. busy stays
// high while a transaction is in work, so only one is handled at a time.
// An insert into a full heap answers in the cycle after acceptance. Any other
// insert opens a hole at the end, moves parents down into it while the new
// value is larger, then writes the value into the hole. A delete first scans
// the heap for the value at one entry per cycle, then reloads the last entry
// into the freed slot and sifts it up or down. The longest case is a hit on
// the next-to-last entry whose replacement rises to the root. All of this is
// set by the heap RAM (one write port and one registered read port, one read
// per cycle) and the one shared signed comparator. The heap RAM needs no
// clearing: only entries below count are ever used. capacity (byte address 0,
// reset 64) caps the number of entries in use at min(capacity, DEPTH); write
// it only while the queue is idle. Lowering it below the count keeps held
// entries.
module max_heap_priority_queue_top #(
   parameter int DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic signed [31:0]            req_value,
   // result channel
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [6:0]                    rsp_count,
   output logic signed [31:0]            rsp_max_value,
   output logic                          rsp_empty_res,
   // register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [2:0]                    paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   logic [mhpq_pkg::CNT_W-1:0]  capacity_ff, capacity_in;
   logic                        csr_wr;

   logic                        mem_we;
   logic [$clog2(DEPTH)-1:0]    mem_waddr;
   logic [mhpq_pkg::DATA_W-1:0] mem_wdata;
   logic [$clog2(DEPTH)-1:0]    mem_raddr;
   logic [mhpq_pkg::DATA_W-1:0] mem_rdata;

   mhpq_pkg::cmp_req_type       cmp_req;
   mhpq_pkg::cmp_res_type       cmp_res;

   logic [mhpq_pkg::DATA_W-1:0] rsp_max_raw;

   // register port: zero wait states, bit 2 of the byte address picks the word
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == mhpq_pkg::REG_CAPACITY);

   always_comb begin
      capacity_in = csr_wr ? pwdata[mhpq_pkg::CNT_W-1:0] : capacity_ff;
      prdata      = (paddr[2] == mhpq_pkg::REG_CAPACITY) ? 32'(capacity_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= mhpq_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   mhpq_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .cmd           (req_cmd),
      .value         (req_value),
      .capacity      (capacity_ff),
      .busy          (busy),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata),
      .cmp_req       (cmp_req),
      .cmp_res       (cmp_res),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_max_value (rsp_max_raw),
      .rsp_empty_res (rsp_empty_res)
   );

   assign rsp_max_value = $signed(rsp_max_raw);

   mhpq_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // single shared comparator for scan, sift-up and sift-down
   mhpq_cmp u_cmp (
      .req (cmp_req),
      .res (cmp_res)
   );

endmodule

[tb/sv/max_heap_priority_queue_top_test.sv]
`timescale 1ns / 100ps

// Checks the max-heap queue against a multiset predictor. The heap's internal
// order never shows on the ports: status, count, max and the empty flag depend
// only on which values are held. So the predictor keeps a plain list of held
// values and recomputes the max on each transaction.
module max_heap_priority_queue_top_test;

   localparam int HEAP_DEPTH      = 64;
   localparam int STALL_LIMIT     = 2000;  // far above the longest delete plus the largest send gap
   localparam int DRAIN_CYCLES    = 100;
   localparam int ITEMS_PER_PHASE = 230;
   localparam logic [2:0] CAP_ADDR = {mhpq_pkg::REG_CAPACITY, 2'b00};

   typedef struct {
      logic [mhpq_pkg::STAT_W-1:0]        status;
      logic [mhpq_pkg::CNT_W-1:0]         count;
      logic signed [mhpq_pkg::DATA_W-1:0] max_value;
      logic                               empty_res;
   } heap_result_type;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   logic                               req_cmd;
   logic signed [mhpq_pkg::DATA_W-1:0] req_value;
   logic                               rsp_valid;
   logic [mhpq_pkg::STAT_W-1:0]        rsp_status;
   logic [mhpq_pkg::CNT_W-1:0]         rsp_count;
   logic signed [mhpq_pkg::DATA_W-1:0] rsp_max_value;
   logic                               rsp_empty_res;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [2:0]                         paddr;
   logic [31:0]                        pwdata;
   logic [31:0]                        prdata;
   logic                               pready;

   // predictor state: held values (any order) and the capacity register copy
   heap_result_type                    expected_results[$];
   logic signed [mhpq_pkg::DATA_W-1:0] held_values[$];
   logic [mhpq_pkg::CNT_W-1:0]         capacity_shadow = mhpq_pkg::CAP_RESET;

   int error_count  = 0;
   int idle_cycles  = 0;
   bit back_to_back = 1'b0;   // when set, the sender issues with no gaps

   max_heap_priority_queue_top #(
      .DEPTH(HEAP_DEPTH)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_max_value(rsp_max_value),
      .rsp_empty_res(rsp_empty_res),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Apply one accepted transaction to the held multiset and queue its result.
   function automatic void apply_heap_op(input logic cmd,
                                         input logic signed [mhpq_pkg::DATA_W-1:0] val);
      heap_result_type                    res;
      int                                 limit;
      int                                 hit;
      logic signed [mhpq_pkg::DATA_W-1:0] top;
      limit = (capacity_shadow > HEAP_DEPTH) ? HEAP_DEPTH : int'(capacity_shadow);
      res.status = mhpq_pkg::STATUS_DONE;
      if (cmd == mhpq_pkg::CMD_INSERT) begin
         // full also covers capacity 0 and capacity lowered below the count
         if (held_values.size() >= limit)
            res.status = mhpq_pkg::STATUS_FULL;
         else
            held_values.push_back(val);
      end else begin
         hit = -1;
         foreach (held_values[i])
            if (hit < 0 && held_values[i] == val)
               hit = i;
         if (hit < 0)
            res.status = mhpq_pkg::STATUS_NOT_FOUND;
         else
            held_values.delete(hit);   // one occurrence only
      end
      top = '0;   // empty heap reports zero
      foreach (held_values[i])
         if (i == 0 || held_values[i] > top)
            top = held_values[i];
      res.count     = mhpq_pkg::CNT_W'(held_values.size());
      res.max_value = top;
      res.empty_res = (held_values.size() == 0);
      expected_results.push_back(res);
   endfunction

   // Result checker: rsp_valid lasts one cycle and cannot be held off.
   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected: status %0d count %0d",
                   rsp_status, rsp_count);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_count !== want.count) begin
               $error("count mismatch: expected %0d, actual %0d", want.count, rsp_count);
               error_count++;
            end
            if (rsp_max_value !== want.max_value) begin
               $error("max_value mismatch: expected %0d, actual %0d",
                      want.max_value, rsp_max_value);
               error_count++;
            end
            if (rsp_empty_res !== want.empty_res) begin
               $error("empty_res mismatch: expected %0d, actual %0d",
                      want.empty_res, rsp_empty_res);
               error_count++;
            end
         end
      end
   end

   // Watchdog: any accepted transaction, result or register access restarts the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // Issue one command. Returns at the accepting edge with start still high,
   // so a zero gap on the next call keeps start asserted back to back.
   task automatic send_op(input logic cmd,
                          input logic signed [mhpq_pkg::DATA_W-1:0] val);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= val;
      do @(posedge clock); while (busy);
      apply_heap_op(cmd, val);
   endtask

   // Drop start and wait until every result is in and the block is idle.
   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0 || busy)
         @(posedge clock);
   endtask

   // Read capacity back and compare with the shadow copy.
   task automatic check_capacity();
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CAP_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== {25'd0, capacity_shadow}) begin
         $error("capacity mismatch: expected %0d, actual %0d", capacity_shadow, prdata);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Write capacity; upper data bits are random and must be dropped.
   task automatic configure_capacity(input logic [mhpq_pkg::CNT_W-1:0] cap);
      logic [31:0] word;
      word                      = $urandom();
      word[mhpq_pkg::CNT_W-1:0] = cap;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CAP_ADDR;
      pwdata  <= word;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      capacity_shadow = cap;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      check_capacity();
   endtask

   // Mix of extremes, small values (duplicates likely) and full-range values.
   function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return $signed($urandom_range(0, 15)) - 8;
         default: return $signed($urandom());
      endcase
   endfunction

   // Mostly delete something held; the rest are likely absent values.
   function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_delete_value();
      if (held_values.size() != 0 && $urandom_range(0, 9) < 8)
         return held_values[$urandom_range(0, held_values.size() - 1)];
      return pick_value();
   endfunction

   task automatic test_reset_state();
      check_capacity();   // expect the reset value
   endtask

   task automatic test_directed_ops();
      send_op(mhpq_pkg::CMD_DELETE, 32'sd0);            // empty heap: not found, max 0
      send_op(mhpq_pkg::CMD_INSERT, -32'sd5);           // all-negative heap
      send_op(mhpq_pkg::CMD_INSERT, 32'sh8000_0000);
      send_op(mhpq_pkg::CMD_INSERT, 32'sh7FFF_FFFF);
      send_op(mhpq_pkg::CMD_INSERT, -32'sd1);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd7);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd7);            // duplicate
      send_op(mhpq_pkg::CMD_DELETE, 32'sd7);            // removes one copy
      send_op(mhpq_pkg::CMD_DELETE, 32'sd12345);        // absent
      send_op(mhpq_pkg::CMD_DELETE, 32'sh7FFF_FFFF);    // delete the max
      send_op(mhpq_pkg::CMD_DELETE, 32'sd7);
      send_op(mhpq_pkg::CMD_DELETE, 32'sd7);            // now absent
      send_op(mhpq_pkg::CMD_DELETE, 32'sh8000_0000);
      send_op(mhpq_pkg::CMD_DELETE, -32'sd1);
      send_op(mhpq_pkg::CMD_DELETE, -32'sd5);           // back to empty
      wait_idle();
   endtask

   task automatic test_capacity_corners();
      send_op(mhpq_pkg::CMD_INSERT, 32'sd10);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd30);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd20);
      wait_idle();
      configure_capacity(7'd1);                         // below the count: entries kept
      send_op(mhpq_pkg::CMD_INSERT, 32'sd40);           // full
      send_op(mhpq_pkg::CMD_DELETE, 32'sd30);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd40);           // still full
      send_op(mhpq_pkg::CMD_DELETE, 32'sd20);
      send_op(mhpq_pkg::CMD_DELETE, 32'sd10);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd50);           // room again
      send_op(mhpq_pkg::CMD_INSERT, 32'sd60);           // full at one
      wait_idle();
      configure_capacity(7'd0);                         // every insert full
      send_op(mhpq_pkg::CMD_DELETE, 32'sd50);
      send_op(mhpq_pkg::CMD_INSERT, 32'sd60);
      wait_idle();
   endtask

   // Each phase fills first (insert-heavy), then drains (delete-heavy), so the
   // heap runs up to full and back down under every capacity setting.
   task automatic test_random_traffic();
      logic [mhpq_pkg::CNT_W-1:0] caps[8];
      int                         pct;
      caps[0] = 7'd127;
      caps[1] = 7'd64;
      caps[2] = 7'd2;
      caps[3] = 7'd0;
      caps[4] = 7'd1;
      caps[5] = mhpq_pkg::CNT_W'($urandom_range(3, 63));
      caps[6] = mhpq_pkg::CNT_W'($urandom_range(65, 126));
      caps[7] = 7'd127;
      foreach (caps[p]) begin
         configure_capacity(caps[p]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 39) == 0)
               back_to_back = !back_to_back;
            pct = (n < ITEMS_PER_PHASE / 2) ? 85 : 25;
            if ($urandom_range(0, 99) < pct)
               send_op(mhpq_pkg::CMD_INSERT, pick_value());
            else
               send_op(mhpq_pkg::CMD_DELETE, pick_delete_value());
         end
         wait_idle();
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_cmd   = mhpq_pkg::CMD_INSERT;
      req_value = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_directed_ops();
      test_capacity_corners();
      configure_capacity(7'd64);
      test_random_traffic();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);   // catch stray results
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
